// File: rtl/spplrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spplrf_pkg
// Shared types, constants and the rate-code decode for the SAS phy page
// link-rate finder.
// ----------------------------------------------------------------------------
package spplrf_pkg;

    // Largest accepted page buffer; a page length of MAX_PAGE_LEN-4 or more
    // marks the page corrupt.
    localparam int MAX_PAGE_LEN = 1024;
    localparam logic [15:0] LEN_LIMIT = 16'(MAX_PAGE_LEN - 4);

    localparam int HDR_BYTES  = 8;
    localparam int DESC_BYTES = 48;

    // Header byte positions
    localparam logic [3:0] POS_LEN_HI    = 4'd2;
    localparam logic [3:0] POS_LEN_LO    = 4'd3;
    localparam logic [3:0] POS_PHY_COUNT = 4'd7;
    localparam logic [3:0] POS_HDR_DONE  = 4'(HDR_BYTES);

    // Descriptor byte offsets
    localparam logic [5:0] OFF_RATE      = 6'd5;
    localparam logic [5:0] OFF_ADDR_LAST = 6'd15;
    localparam logic [5:0] OFF_DESC_LAST = 6'(DESC_BYTES - 1);

    // Negotiated rate codes
    localparam logic [3:0] RATE_1G5  = 4'h8;
    localparam logic [3:0] RATE_3G   = 4'h9;
    localparam logic [3:0] RATE_6G   = 4'ha;
    localparam logic [3:0] RATE_12G  = 4'hb;
    localparam logic [3:0] RATE_22G5 = 4'hc;

    typedef enum logic [1:0] {
        DS_SEARCHING = 2'd0,
        DS_FOUND     = 2'd1,
        DS_CORRUPT   = 2'd2,
        DS_EXHAUSTED = 2'd3
    } t_decision;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_BUG     = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] speed;
    } t_result;

    function automatic t_result decode_rate(t_decision dec, logic [3:0] code);
        t_result res;
        res.status = ST_BUG;
        res.speed  = 15'd0;
        if (dec == DS_CORRUPT) begin
            res.status = ST_CORRUPT;
        end else if (dec == DS_FOUND) begin
            res.status = ST_FOUND;
            unique case (code)
                RATE_1G5:  res.speed = 15'd1500;
                RATE_3G:   res.speed = 15'd3000;
                RATE_6G:   res.speed = 15'd6000;
                RATE_12G:  res.speed = 15'd12000;
                RATE_22G5: res.speed = 15'd22500;
                default: begin
                    res.status = ST_BUG;
                    res.speed  = 15'd0;
                end
            endcase
        end
        return res;
    endfunction

endpackage

// File: rtl/spplrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spplrf_page_if / spplrf_result_if
// Valid/ready channels for page bytes in and link-rate results out.
// ----------------------------------------------------------------------------
interface spplrf_page_if;
    logic       valid;
    logic       ready;
    logic [7:0] page_byte;
    logic       end_of_page;

    modport source (output valid, output page_byte, output end_of_page, input ready);
    modport sink   (input valid, input page_byte, input end_of_page, output ready);
endinterface

interface spplrf_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_status;
    logic [14:0] link_speed_mbps;

    modport source (output valid, output result_status, output link_speed_mbps, input ready);
    modport sink   (input valid, input result_status, input link_speed_mbps, output ready);
endinterface

// File: rtl/spplrf_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spplrf_walker
// Page state: header decode, descriptor walk, address match and decision.
// ----------------------------------------------------------------------------
module spplrf_walker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [63:0]            i_target,
    output spplrf_pkg::t_result    o_result
);

    logic [3:0]             r_pos,     n_pos;
    logic [15:0]            r_len,     n_len;
    logic [7:0]             r_phys,    n_phys;
    logic [7:0]             r_desc,    n_desc;
    logic [5:0]             r_off,     n_off;
    logic                   r_match,   n_match;
    logic [3:0]             r_pend,    n_pend;
    logic [3:0]             r_chosen,  n_chosen;
    spplrf_pkg::t_decision  r_dec,     n_dec;

    logic [7:0]  tgt_byte;
    logic        match_now;
    logic [7:0]  desc_inc;

    // Start of descriptor n is 8 + 48*n; corrupt once it reaches length+4.
    function automatic logic start_past_len(logic [7:0] num, logic [15:0] len);
        logic [13:0] start;
        start = 14'(spplrf_pkg::HDR_BYTES) + {1'b0, num, 5'b0} + {2'b0, num, 4'b0};
        return {3'b0, start} >= ({1'b0, len} + 17'd4);
    endfunction

    assign tgt_byte  = i_target[{~r_off[2:0], 3'b000} +: 8];
    assign match_now = r_match && (tgt_byte == i_byte);
    assign desc_inc  = r_desc + 8'd1;

    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_phys   = r_phys;
        n_desc   = r_desc;
        n_off    = r_off;
        n_match  = r_match;
        n_pend   = r_pend;
        n_chosen = r_chosen;
        n_dec    = r_dec;

        if (r_dec == spplrf_pkg::DS_SEARCHING) begin
            if (r_pos != spplrf_pkg::POS_HDR_DONE) begin
                priority if (r_pos == spplrf_pkg::POS_LEN_HI) begin
                    n_len = {i_byte, 8'h00};
                end else if (r_pos == spplrf_pkg::POS_LEN_LO) begin
                    n_len = {r_len[15:8], i_byte};
                    if (n_len >= spplrf_pkg::LEN_LIMIT) begin
                        n_dec = spplrf_pkg::DS_CORRUPT;
                    end
                end else if (r_pos == spplrf_pkg::POS_PHY_COUNT) begin
                    n_phys = i_byte;
                    if (i_byte == 8'd0) begin
                        n_dec = spplrf_pkg::DS_EXHAUSTED;
                    end else if (start_past_len(8'd0, r_len)) begin
                        n_dec = spplrf_pkg::DS_CORRUPT;
                    end
                end else begin
                    n_len = r_len;
                end
            end else begin
                if (r_off == spplrf_pkg::OFF_RATE) begin
                    n_pend = i_byte[3:0];
                end
                if (r_off[5:3] == 3'd1) begin
                    n_match = match_now;
                end
                if (r_off == spplrf_pkg::OFF_ADDR_LAST && match_now) begin
                    n_dec    = spplrf_pkg::DS_FOUND;
                    n_chosen = r_pend;
                end else if (r_off == spplrf_pkg::OFF_DESC_LAST) begin
                    n_off   = 6'd0;
                    n_desc  = desc_inc;
                    n_match = 1'b1;
                    if (desc_inc >= r_phys) begin
                        n_dec = spplrf_pkg::DS_EXHAUSTED;
                    end else if (start_past_len(desc_inc, r_len)) begin
                        n_dec = spplrf_pkg::DS_CORRUPT;
                    end
                end else begin
                    n_off = r_off + 6'd1;
                end
            end
        end

        // only the header positions matter, so hold the position at its end
        if (r_pos != spplrf_pkg::POS_HDR_DONE) begin
            n_pos = r_pos + 4'd1;
        end
    end

    assign o_result = spplrf_pkg::decode_rate(n_dec, n_chosen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos    <= 4'd0;
            r_len    <= 16'd0;
            r_phys   <= 8'd0;
            r_desc   <= 8'd0;
            r_off    <= 6'd0;
            r_match  <= 1'b1;
            r_pend   <= 4'd0;
            r_chosen <= 4'd0;
            r_dec    <= spplrf_pkg::DS_SEARCHING;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_phys   <= n_phys;
            r_desc   <= n_desc;
            r_off    <= n_off;
            r_match  <= n_match;
            r_pend   <= n_pend;
            r_chosen <= n_chosen;
            r_dec    <= n_dec;
        end
    end

    a_off_in_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= spplrf_pkg::OFF_DESC_LAST)
        else $error("descriptor offset ran past the descriptor");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == 4'd0 && r_dec == spplrf_pkg::DS_SEARCHING)
        else $error("page state not cleared after final byte");

    a_decision_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec != spplrf_pkg::DS_SEARCHING && !(i_step && i_last) |=> r_dec == $past(r_dec))
        else $error("decision changed before end of page");

    a_walk_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != spplrf_pkg::POS_HDR_DONE |-> r_off == 6'd0 && r_desc == 8'd0)
        else $error("descriptor walk started inside the header");

endmodule

// File: rtl/sas_phy_page_link_rate_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_phy_page_link_rate_finder
// Finds the negotiated link speed of one SAS phy in a phy control and
// discover mode page streamed in byte by byte.
// ----------------------------------------------------------------------------
// Feed the page one byte per word on i_page, byte 0 first, with end_of_page
// set on the final byte. The block decodes the 8-byte header (page length,
// phy count), walks the 48-byte phy descriptors and compares each SAS
// address with the target written through i_cfg_wr_en/i_cfg_wr_data (write
// it only while no page is in flight). Exactly one word leaves on o_result
// per page, after the final byte: status 0 with the speed in Mbit/s, status
// 1 for a corrupt page (length too large, or a descriptor beyond the page
// length), status 2 for no match, no phys, an early end or a bad rate code.
// Throughput is one byte per clock unless the input stalls: each byte passes
// the input register, then counter and compare logic updates the page state
// and, on the final byte, loads the result register. o_result.valid rises as
// that result register is loaded. Input stalls only when a final byte waits
// in the input register while the previous result is still held in the
// result register and not taken in that cycle.
// ----------------------------------------------------------------------------
module sas_phy_page_link_rate_finder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [63:0]     i_cfg_wr_data,
    spplrf_page_if.sink     i_page,
    spplrf_result_if.source o_result
);

    logic [63:0]          r_target;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    spplrf_pkg::t_result  r_out;

    logic                 out_free;
    logic                 step;
    spplrf_pkg::t_result  walk_res;

    // Result slot frees when empty or being taken this cycle.
    assign out_free = !r_out_valid || o_result.ready;
    // Advance a held byte unless it is a final byte with no place for its result.
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign i_page.ready = !r_in_valid || step;

    // Target address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 64'd0;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_page.valid && i_page.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_page.valid && i_page.ready) begin
            r_in_byte <= i_page.page_byte;
            r_in_last <= i_page.end_of_page;
        end
    end

    spplrf_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_target (r_target),
        .o_result (walk_res)
    );

    // Result register: load on the final byte, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= walk_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.result_status   = r_out.status;
    assign o_result.link_speed_mbps = r_out.speed;

endmodule
